[rtl/smrc_pkg.sv]
// ----------------------------------------------------------------------------
// Shutter motor relay control package
// Shared payload types, input kind codes and register indexes.
// ----------------------------------------------------------------------------
package smrc_pkg;

  localparam int FieldW   = 10;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int KindW    = 2;

  // Input kinds
  localparam logic [KindW-1:0] KindUp   = 2'd0;
  localparam logic [KindW-1:0] KindDown = 2'd1;
  localparam logic [KindW-1:0] KindOff  = 2'd2;
  localparam logic [KindW-1:0] KindTick = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegLongRun   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegShortRun  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLongMask  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGuardTick = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStagger   = 3'd4;

  // Register reset values
  localparam logic [15:0]       LongRunRst   = 16'd3500;
  localparam logic [15:0]       ShortRunRst  = 16'd2500;
  localparam logic [FieldW-1:0] LongMaskRst  = 10'd49;
  localparam logic [7:0]        GuardTickRst = 8'd30;
  localparam logic [7:0]        StaggerRst   = 8'd20;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [FieldW-1:0] channel_mask;
  } in_item_t;

  typedef struct packed {
    logic [FieldW-1:0] direction_relays;
    logic [FieldW-1:0] power_relays;
    logic [FieldW-1:0] moving_channels;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the accepted input item, clear the stagger delay
    logic walk;     // process the channel at the current index
    logic publish;  // load the result register
  } dp_cmd_t;

endpackage

[rtl/smrc_controller.sv]
// ----------------------------------------------------------------------------
// Shutter motor relay control sequencer
// Walks the channel index once per item and runs the output handshake.
// ----------------------------------------------------------------------------
module smrc_controller #(
  parameter  int CHANNELS = 10,
  localparam int ChanW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output smrc_pkg::dp_cmd_t cmd_o,
  output logic [ChanW-1:0] chan_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StWalk   = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  localparam logic [ChanW-1:0] LastChan = ChanW'(CHANNELS - 1);

  logic [1:0]       state_q, state_d;
  logic [ChanW-1:0] chan_q, chan_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    chan_d      = chan_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          chan_d        = '0;
          state_d       = StWalk;
        end
      end
      StWalk: begin
        cmd_o.walk = 1'b1;
        if (chan_q == LastChan) begin
          state_d = StFinish;
        end else begin
          chan_d = chan_q + 1'b1;
        end
      end
      StFinish: begin
        // Hold until the result register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign chan_o      = chan_q;

endmodule

[rtl/smrc_datapath.sv]
// ----------------------------------------------------------------------------
// Shutter motor relay control datapath
// Configuration registers, per-channel mode and timers, relay bitmaps and
// the result register.
// ----------------------------------------------------------------------------
module smrc_datapath #(
  parameter  int CHANNELS = 10,
  localparam int ChanW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [smrc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [smrc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  smrc_pkg::in_item_t              in_data_i,
  input  smrc_pkg::dp_cmd_t               cmd_i,
  input  logic [ChanW-1:0]                chan_i,
  output smrc_pkg::out_item_t             out_data_o
);

  localparam int FieldW = smrc_pkg::FieldW;

  localparam logic [2:0] ModeUpStart   = 3'd0;
  localparam logic [2:0] ModeUp        = 3'd1;
  localparam logic [2:0] ModeDownStart = 3'd2;
  localparam logic [2:0] ModeDown      = 3'd3;
  localparam logic [2:0] ModeStopStart = 3'd4;
  localparam logic [2:0] ModeStop      = 3'd5;

  // Configuration
  logic [15:0]       long_run_q, short_run_q;
  logic [FieldW-1:0] long_mask_q;
  logic [7:0]        guard_ticks_q, stagger_q;

  // Current item
  logic [smrc_pkg::KindW-1:0] kind_q;
  logic [FieldW-1:0]          mask_q;
  logic [11:0]                delay_q, delay_d;

  // Channel state
  logic [2:0]          mode_q  [CHANNELS];
  logic [15:0]         run_q   [CHANNELS];
  logic [11:0]         guard_q [CHANNELS];
  logic [CHANNELS-1:0] dir_q, pwr_q, moving_q;

  smrc_pkg::out_item_t out_q;

  logic [CHANNELS-1:0] sel_vec, long_vec;
  logic [FieldW-1:0]   dir_out, pwr_out, mov_out;

  logic        is_tick, selected;
  logic [11:0] delay_eff;
  logic [15:0] max_run;
  logic [2:0]  m;
  logic [15:0] r;
  logic [11:0] g;
  logic        pw, dr;
  logic [12:0] delay_sum;

  // Channels at or above the field width are never addressed by a command
  // and always take the short run time.
  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan_vec
    if (i < FieldW) begin : g_in
      assign sel_vec[i]  = mask_q[i];
      assign long_vec[i] = long_mask_q[i];
    end else begin : g_out
      assign sel_vec[i]  = 1'b0;
      assign long_vec[i] = 1'b0;
    end
  end

  for (genvar j = 0; j < FieldW; j++) begin : g_out_vec
    if (j < CHANNELS) begin : g_in
      assign dir_out[j] = dir_q[j];
      assign pwr_out[j] = pwr_q[j];
      assign mov_out[j] = moving_q[j];
    end else begin : g_out
      assign dir_out[j] = 1'b0;
      assign pwr_out[j] = 1'b0;
      assign mov_out[j] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_run_q    <= smrc_pkg::LongRunRst;
      short_run_q   <= smrc_pkg::ShortRunRst;
      long_mask_q   <= smrc_pkg::LongMaskRst;
      guard_ticks_q <= smrc_pkg::GuardTickRst;
      stagger_q     <= smrc_pkg::StaggerRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        smrc_pkg::RegLongRun:   long_run_q    <= cfg_wdata_i;
        smrc_pkg::RegShortRun:  short_run_q   <= cfg_wdata_i;
        smrc_pkg::RegLongMask:  long_mask_q   <= cfg_wdata_i[FieldW-1:0];
        smrc_pkg::RegGuardTick: guard_ticks_q <= cfg_wdata_i[7:0];
        smrc_pkg::RegStagger:   stagger_q     <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // One channel per cycle: tick countdown, pending start, then transition
  always_comb begin
    is_tick   = (kind_q == smrc_pkg::KindTick);
    selected  = is_tick || sel_vec[chan_i];
    delay_eff = is_tick ? 12'd0 : delay_q;
    max_run   = long_vec[chan_i] ? long_run_q : short_run_q;
    m  = mode_q[chan_i];
    r  = run_q[chan_i];
    g  = guard_q[chan_i];
    pw = pwr_q[chan_i];
    dr = dir_q[chan_i];

    if (is_tick) begin
      if (g != 12'd0) begin
        g = g - 12'd1;
      end else if (r != 16'd0) begin
        r  = r - 16'd1;
        pw = 1'b1;
      end else if (pw) begin
        pw = 1'b0;
        dr = 1'b0;
        g  = {4'd0, guard_ticks_q};
      end
    end

    unique case (m)
      ModeUpStart: begin
        if (delay_eff > g) begin
          g = delay_eff;
        end
        r  = max_run;
        dr = 1'b1;
        m  = ModeUp;
      end
      ModeDownStart: begin
        if (delay_eff > g) begin
          g = delay_eff;
        end
        r  = max_run;
        dr = 1'b0;
        m  = ModeDown;
      end
      ModeStopStart: begin
        dr = 1'b0;
        if (pw) begin
          pw = 1'b0;
          g  = {4'd0, guard_ticks_q};
        end
        r = 16'd0;
        m = ModeStop;
      end
      default: ;
    endcase

    unique case (m)
      ModeUp: begin
        if (kind_q == smrc_pkg::KindDown) begin
          m = (r != 16'd0) ? ModeStopStart : ModeDownStart;
        end else if (kind_q == smrc_pkg::KindUp && r == 16'd0) begin
          m = ModeUpStart;
        end
      end
      ModeDown: begin
        if (kind_q == smrc_pkg::KindUp) begin
          m = (r != 16'd0) ? ModeStopStart : ModeUpStart;
        end
      end
      default: begin
        if (kind_q == smrc_pkg::KindUp) begin
          m = ModeUpStart;
        end else if (kind_q == smrc_pkg::KindDown) begin
          m = ModeDownStart;
        end else begin
          m = ModeStop;
        end
      end
    endcase

    // Saturate the stagger delay at the guard timer range
    delay_sum = {1'b0, delay_q} + {5'd0, stagger_q};
    delay_d   = delay_sum[12] ? 12'hFFF : delay_sum[11:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= in_data_i.kind;
      mask_q  <= in_data_i.channel_mask;
      delay_q <= 12'd0;
    end else if (cmd_i.walk && selected && !is_tick) begin
      delay_q <= delay_d;
    end
    if (cmd_i.publish) begin
      out_q.direction_relays <= dir_out;
      out_q.power_relays     <= pwr_out;
      out_q.moving_channels  <= mov_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        mode_q[i]  <= ModeStop;
        run_q[i]   <= 16'd0;
        guard_q[i] <= 12'd0;
      end
      dir_q    <= '0;
      pwr_q    <= '0;
      moving_q <= '0;
    end else if (cmd_i.walk && selected) begin
      mode_q[chan_i]   <= m;
      run_q[chan_i]    <= r;
      guard_q[chan_i]  <= g;
      dir_q[chan_i]    <= dr;
      pwr_q[chan_i]    <= pw;
      moving_q[chan_i] <= (r != 16'd0);
    end
  end

  assign out_data_o = out_q;

endmodule

[rtl/shutter_motor_relay_control_unit.sv]
// ----------------------------------------------------------------------------
// Shutter motor relay control unit
// Relay sequencing for CHANNELS roller shutter motors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one item per
//   transfer: an up, down or off command with a channel mask, or a 10 ms tick.
//   Output channel (out_valid_o/out_ready_i/out_data_o) returns one result per
//   item: direction relays, power relays and moving channels.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 long run time, 1 short run time, 2 long channel mask, 3 relay guard
//   ticks, 4 stagger ticks); other indexes are ignored. Write only when idle.
//   Timing: the sequencer visits one channel per cycle, so an item occupies
//   the block for the accept step, one step per channel and the step that
//   loads the result register. The result is registered, so out_valid_o
//   rises after the load step; a new item is only accepted once the load
//   step is through.
//   Stall: the result register holds its item until taken; the next item is
//   accepted while a result waits, but its own result is not loaded until
//   the register drains.
//   Reset: all channels stop, timers and relay bits clear, configuration
//   registers return to their defaults.
// ----------------------------------------------------------------------------
module shutter_motor_relay_control_unit #(
  parameter int CHANNELS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [smrc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [smrc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  smrc_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output smrc_pkg::out_item_t           out_data_o
);

  localparam int ChanW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  smrc_pkg::dp_cmd_t cmd;
  logic [ChanW-1:0]  chan;

  // Sequencer: accept, walk every channel, publish
  smrc_controller #(
    .CHANNELS(CHANNELS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .chan_o     (chan)
  );

  // Per-channel state machines, timers and relay bitmaps
  smrc_datapath #(
    .CHANNELS(CHANNELS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .chan_i     (chan),
    .out_data_o (out_data_o)
  );

endmodule

[rtl/smrc_checker.sv]
// ----------------------------------------------------------------------------
// Shutter motor relay control checker
// Port-level timing checks, bound to the top level.
// ----------------------------------------------------------------------------
module smrc_checker #(
  parameter int CHANNELS = 10
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input smrc_pkg::out_item_t out_data_o
);

  // Busy right after a transfer in, still busy on the last channel step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while previous item in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##(CHANNELS) !in_ready_o)
    else $error("input ready before channel walk finished");

  // With the result register empty, the result shows once the walk and the load step are through
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |-> ##(CHANNELS + 2) out_valid_o)
    else $error("result missing after fixed latency");

  // A new result appears only after the walk, never while ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result published while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind shutter_motor_relay_control_unit smrc_checker #(
  .CHANNELS(CHANNELS)
) u_smrc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
